>>> design/twam_pkg.sv
// twam_pkg: shared types and constants of the two-wire register access master
// used by every module of the block and by its checker; no dependencies
`timescale 1ns / 1ps

package twam_pkg;

    // bits per address and data byte on the serial line
    localparam int DATA_BITS = 8;
    localparam int BIT_W     = $clog2(DATA_BITS);
    localparam logic [BIT_W-1:0] FIRST_BIT = BIT_W'(DATA_BITS - 1);

    // top address bit marks a write
    localparam logic [DATA_BITS-1:0] WRITE_FLAG = DATA_BITS'(1) << (DATA_BITS - 1);

    // request type codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_REC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REC  = 2'd2;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] TURNAROUND_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] READ_REC_RST   = 16'd1;
    localparam logic [CFG_DATA_W-1:0] WRITE_REC_RST  = 16'd100;

    // command queue depth
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [6:0]           reg_addr;
        logic [DATA_BITS-1:0] write_data;
        logic                 sdio_in;
    } t_in_item;

    typedef struct packed {
        logic                 sck_level;
        logic                 sdio_out;
        logic                 sdio_drive;
        logic [DATA_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 rejected;
    } t_out_item;

    // classified tick as it travels from front to back
    typedef struct packed {
        logic                 start;
        logic                 rd;
        logic [DATA_BITS-1:0] shift_byte;
        logic [DATA_BITS-1:0] data_init;
        logic                 sdio_in;
    } t_cmd;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] turnaround_ticks;
        logic [CFG_DATA_W-1:0] read_recovery_ticks;
        logic [CFG_DATA_W-1:0] write_recovery_ticks;
    } t_cfg;

endpackage

>>> design/twam_front.sv
// twam_front: accepts ticks and classifies them into queue commands
// depends on twam_pkg
`timescale 1ns / 1ps

module twam_front
    import twam_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic is_rd;
    logic is_wr;

    assign is_rd = (i_in_data.req_type == REQ_READ);
    assign is_wr = (i_in_data.req_type == REQ_WRITE);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.start      = is_rd || is_wr;
        o_cmd.rd         = is_rd;
        // address byte with the direction flag on top
        o_cmd.shift_byte = is_rd ? {1'b0, i_in_data.reg_addr}
                                 : ({1'b0, i_in_data.reg_addr} | WRITE_FLAG);
        o_cmd.data_init  = is_rd ? '0 : i_in_data.write_data;
        o_cmd.sdio_in    = i_in_data.sdio_in;
    end

endmodule

>>> design/twam_queue.sv
// twam_queue: short command queue between front and back
// depends on twam_pkg
`timescale 1ns / 1ps

module twam_queue
    import twam_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/twam_back.sv
// twam_back: serial access sequencer, one queue command per tick, output register
// depends on twam_pkg
`timescale 1ns / 1ps

module twam_back
    import twam_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ADDR    = 3'd1;
    localparam logic [2:0] PH_TURN    = 3'd2;
    localparam logic [2:0] PH_WDATA   = 3'd3;
    localparam logic [2:0] PH_RDATA   = 3'd4;
    localparam logic [2:0] PH_RECOVER = 3'd5;

    logic [2:0]            r_phase,     n_phase;
    logic [BIT_W-1:0]      r_bit_count, n_bit_count;
    logic                  r_half_tick, n_half_tick;
    logic [DATA_BITS-1:0]  r_shift_reg, n_shift_reg;
    logic [DATA_BITS-1:0]  r_data_hold, n_data_hold;
    logic                  r_is_read,   n_is_read;
    logic [CFG_DATA_W-1:0] r_wait,      n_wait;
    logic [DATA_BITS-1:0]  r_last_read, n_last_read;
    logic                  r_out_valid;
    t_out_item             r_out_data;
    t_out_item             n_out_data;

    logic                  last_bit;
    logic                  go_turn;
    logic                  go_data;
    logic                  go_rec;
    logic                  go_fin;
    logic [CFG_DATA_W-1:0] rec_ticks;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_half_tick = r_half_tick;
        n_shift_reg = r_shift_reg;
        n_data_hold = r_data_hold;
        n_is_read   = r_is_read;
        n_wait      = r_wait;
        n_last_read = r_last_read;
        last_bit    = 1'b0;
        go_turn     = 1'b0;
        go_data     = 1'b0;
        go_rec      = 1'b0;
        go_fin      = 1'b0;
        rec_ticks   = '0;

        n_out_data            = '0;
        n_out_data.sck_level  = 1'b1;

        // unused codes fall back to idle
        if (n_phase < PH_ADDR || n_phase > PH_RECOVER) begin
            n_phase = PH_IDLE;
        end

        if (n_phase != PH_IDLE) begin
            n_out_data.rejected = i_cmd.start;
        end else if (i_cmd.start) begin
            n_is_read   = i_cmd.rd;
            n_shift_reg = i_cmd.shift_byte;
            n_data_hold = i_cmd.data_init;
            n_bit_count = FIRST_BIT;
            n_half_tick = 1'b0;
            n_phase     = PH_ADDR;
        end

        case (n_phase)
            PH_ADDR, PH_WDATA, PH_RDATA: begin
                n_out_data.busy_res  = 1'b1;
                n_out_data.sck_level = n_half_tick;
                if (n_phase == PH_ADDR) begin
                    n_out_data.sdio_out   = n_shift_reg[n_bit_count];
                    n_out_data.sdio_drive = 1'b1;
                end else if (n_phase == PH_WDATA) begin
                    n_out_data.sdio_out   = n_data_hold[n_bit_count];
                    n_out_data.sdio_drive = 1'b1;
                end else if (n_half_tick) begin
                    // sample on the high tick
                    n_data_hold[n_bit_count] = i_cmd.sdio_in;
                end
                // advance one half of the bit cell
                if (!n_half_tick) begin
                    n_half_tick = 1'b1;
                end else begin
                    n_half_tick = 1'b0;
                    if (n_bit_count == '0) begin
                        last_bit = 1'b1;
                    end else begin
                        n_bit_count = n_bit_count - 1'b1;
                    end
                end
                if (last_bit) begin
                    if (n_phase == PH_ADDR) begin
                        go_turn = 1'b1;
                    end else begin
                        go_rec = 1'b1;
                    end
                end
            end
            PH_TURN: begin
                n_out_data.busy_res   = 1'b1;
                n_out_data.sdio_out   = n_shift_reg[0];
                n_out_data.sdio_drive = 1'b1;
                if (n_wait != '0) begin
                    n_wait = n_wait - 1'b1;
                end
                if (n_wait == '0) begin
                    go_data = 1'b1;
                end
            end
            PH_RECOVER: begin
                n_out_data.busy_res = 1'b1;
                if (n_wait != '0) begin
                    n_wait = n_wait - 1'b1;
                end
                if (n_wait == '0) begin
                    go_fin = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (go_turn) begin
            if (i_cfg.turnaround_ticks == '0) begin
                go_data = 1'b1;
            end else begin
                n_wait  = i_cfg.turnaround_ticks;
                n_phase = PH_TURN;
            end
        end
        if (go_data) begin
            n_bit_count = FIRST_BIT;
            n_half_tick = 1'b0;
            n_phase     = n_is_read ? PH_RDATA : PH_WDATA;
        end
        if (go_rec) begin
            rec_ticks = n_is_read ? i_cfg.read_recovery_ticks : i_cfg.write_recovery_ticks;
            if (rec_ticks == '0) begin
                go_fin = 1'b1;
            end else begin
                n_wait  = rec_ticks;
                n_phase = PH_RECOVER;
            end
        end
        if (go_fin) begin
            n_out_data.done_res = 1'b1;
            if (n_is_read) begin
                n_last_read = n_data_hold;
            end
            n_phase = PH_IDLE;
        end

        n_out_data.read_data = n_last_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_half_tick <= 1'b0;
            r_shift_reg <= '0;
            r_data_hold <= '0;
            r_is_read   <= 1'b0;
            r_wait      <= '0;
            r_last_read <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_half_tick <= n_half_tick;
                r_shift_reg <= n_shift_reg;
                r_data_hold <= n_data_hold;
                r_is_read   <= n_is_read;
                r_wait      <= n_wait;
                r_last_read <= n_last_read;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> design/two_wire_register_access_master.sv
// two_wire_register_access_master: top level, configuration registers and the
// front, queue and back parts; depends on twam_pkg, twam_front, twam_queue, twam_back
`timescale 1ns / 1ps

// usage
//   every input transaction is one timing tick of the serial clock generator:
//   req_type starts a read or a write, or just lets the current access advance,
//   sdio_in carries the sampled data line level for that tick
//   every tick gives exactly one output transaction with the clock level, data
//   line drive and level, last read byte and done, busy and rejected flags
//   the front classifies ticks into a four-entry command queue, the back runs the
//   access sequencer into an output register, one command per clock unless stalled
// throughput
//   one transaction per clock while the output is taken; an accepted tick is
//   written into the queue and then into the output register before it shows
// reset
//   synchronous active-low reset empties the queue and output register, puts
//   the sequencer in idle and loads turnaround 100, read recovery 1 and write
//   recovery 100; no clearing pass is needed
// stalls
//   while the output is not taken the back holds its state and the queue fills;
//   input ready drops only once the queue is full
// configuration
//   plain write port, register index 0 turnaround, 1 read recovery, 2 write
//   recovery, others ignored; user must write while no access is running, unenforced
module two_wire_register_access_master
    import twam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    // front to queue
    logic q_full;
    logic push;
    t_cmd push_cmd;

    // queue to back
    logic q_valid;
    logic pop;
    t_cmd head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turnaround_ticks     <= TURNAROUND_RST;
            r_cfg.read_recovery_ticks  <= READ_REC_RST;
            r_cfg.write_recovery_ticks <= WRITE_REC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TURNAROUND: r_cfg.turnaround_ticks     <= i_cfg_data;
                CFG_READ_REC:   r_cfg.read_recovery_ticks  <= i_cfg_data;
                CFG_WRITE_REC:  r_cfg.write_recovery_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // decode request type and build the address byte
    twam_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // lets the front keep taking ticks while the output stalls, until the queue is full
    twam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // address, turnaround, data and recovery sequencing
    twam_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/twam_checker.sv
// twam_checker: port-level assertions for the two-wire register access master
// depends on twam_pkg; bound to two_wire_register_access_master
`timescale 1ns / 1ps

module twam_checker
    import twam_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output transaction changed while stalled");

    // completion only inside an access
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.done_res |-> i_out_data.busy_res)
        else $error("done without busy");

    // rejection only while an access runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.rejected |-> i_out_data.busy_res)
        else $error("rejected outside an access");

    // released line reads low; the idle clock level (high) is not checked here
    a_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.sdio_drive |-> !i_out_data.sdio_out)
        else $error("sdio_out high while released");

    // nothing shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind two_wire_register_access_master twam_checker u_twam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
